### src/bgp_pkg.sv
package bgp_pkg;

  // Item kinds
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // Sequential fetch step and pattern counter limits
  localparam logic [31:0] SEQ_STEP  = 32'd4;
  localparam logic [1:0]  CTR_MIN   = 2'd0;
  localparam logic [1:0]  CTR_TAKEN = 2'd2;
  localparam logic [1:0]  CTR_MAX   = 2'd3;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified item handed from front to back
  typedef struct packed {
    logic        lookup;   // look up tables and count hit or miss
    logic        branch;   // resolve item that trains the tables
    logic        taken;    // actual outcome of a branch
    logic [31:0] pc;
    logic [31:0] next_pc;
    logic [31:0] seq_pc;   // pc + 4
  } item_t;

endpackage

### src/bgp_ram.sv
module bgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bgp_front.sv
module bgp_front (
  input  logic                start,
  input  logic                kind,
  input  logic [31:0]         pc,
  input  logic [31:0]         next_pc,
  input  logic                full,
  input  logic                clearing,
  output logic                busy,
  output logic                push,
  output bgp_pkg::item_t      item
);

  logic [31:0] seq_pc;
  logic        resolve;
  logic        moved;

  // Hold off new items while the queue is full or the tables are being cleared
  assign busy = full | clearing;
  assign push = start & ~busy;

  // Classify the item: a resolve that stays on its own pc is a no-op
  assign seq_pc  = pc + bgp_pkg::SEQ_STEP;
  assign resolve = (kind == bgp_pkg::KIND_RESOLVE);
  assign moved   = (next_pc != pc);

  assign item.lookup  = ~resolve | moved;
  assign item.branch  = resolve & moved;
  assign item.taken   = resolve & moved & (next_pc != seq_pc);
  assign item.pc      = pc;
  assign item.next_pc = next_pc;
  assign item.seq_pc  = seq_pc;

endmodule

### src/bgp_queue.sv
module bgp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bgp_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output bgp_pkg::item_t head
);

  localparam int PTR_W = $clog2(bgp_pkg::QUEUE_DEPTH);

  bgp_pkg::item_t   entries [bgp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(bgp_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

### src/bgp_back.sv
module bgp_back #(
  parameter int BTB_ENTRIES  = 1024,
  parameter int PHT_ENTRIES  = 256,
  parameter int HISTORY_BITS = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bgp_pkg::item_t q_item,
  output logic           pop,
  output logic           clearing,
  output logic           done,
  output logic [31:0]    predicted_next_pc,
  output logic           tag_hit,
  output logic           taken_guess,
  output logic           is_branch,
  output logic           prediction_correct,
  output logic [31:0]    branch_total,
  output logic [31:0]    correct_total,
  output logic [31:0]    hit_total,
  output logic [31:0]    miss_total
);

  localparam int BTB_AW    = $clog2(BTB_ENTRIES);
  localparam int PHT_AW    = $clog2(PHT_ENTRIES);
  localparam int TAG_W     = 32 - BTB_AW;
  localparam int BTB_W     = 1 + TAG_W + 32;
  localparam int MAX_DEPTH = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int CLR_W     = $clog2(MAX_DEPTH) + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t              state;
  logic [CLR_W-1:0]    clr_cnt;
  bgp_pkg::item_t      cur;
  logic [PHT_AW-1:0]   cur_pidx;
  logic [HISTORY_BITS-1:0] history;

  logic [31:0]         hist_ext;
  logic [BTB_AW-1:0]   head_slot;
  logic [PHT_AW-1:0]   head_pidx;

  logic                btb_we;
  logic [BTB_AW-1:0]   btb_waddr;
  logic [BTB_W-1:0]    btb_wdata;
  logic [BTB_W-1:0]    btb_rdata;
  logic                pht_we;
  logic [PHT_AW-1:0]   pht_waddr;
  logic [1:0]          pht_wdata;
  logic [1:0]          pht_rdata;

  logic [BTB_AW-1:0]   cur_slot;
  logic [TAG_W-1:0]    cur_tag;
  logic                rd_valid;
  logic [TAG_W-1:0]    rd_tag;
  logic [31:0]         rd_addr;
  logic                hit;
  logic [31:0]         tgt;
  logic                ptaken;
  logic [31:0]         pred_pc;
  logic                correct;
  logic                fix_target;
  logic [1:0]          ctr_next;

  // Index the tables for the item at the head of the queue
  assign hist_ext  = 32'(history);
  assign head_slot = q_item.pc[BTB_AW+1:2];
  assign head_pidx = q_item.pc[PHT_AW+1:2] ^ hist_ext[PHT_AW-1:0];

  assign pop      = (state == ST_IDLE) && q_valid;
  assign clearing = (state == ST_CLEAR);

  // Evaluate the item whose table entries were read last cycle
  assign cur_slot   = cur.pc[BTB_AW+1:2];
  assign cur_tag    = cur.pc[31:BTB_AW];
  assign rd_valid   = btb_rdata[BTB_W-1];
  assign rd_tag     = btb_rdata[BTB_W-2:32];
  assign rd_addr    = btb_rdata[31:0];
  assign hit        = cur.lookup && rd_valid && (rd_tag == cur_tag);
  assign tgt        = hit ? rd_addr : '0;
  assign ptaken     = cur.lookup && (tgt != '0) && (pht_rdata >= bgp_pkg::CTR_TAKEN);
  assign pred_pc    = !cur.lookup ? '0 : (ptaken ? tgt : cur.seq_pc);
  assign correct    = cur.branch && (ptaken == cur.taken);
  assign fix_target = cur.branch && cur.taken && ((tgt == '0) || (tgt != cur.next_pc));

  // Saturate the pattern counter toward the outcome
  always_comb begin
    ctr_next = pht_rdata;
    if (cur.taken) begin
      if (pht_rdata != bgp_pkg::CTR_MAX) begin
        ctr_next = pht_rdata + 2'd1;
      end
    end else begin
      if (pht_rdata != bgp_pkg::CTR_MIN) begin
        ctr_next = pht_rdata - 2'd1;
      end
    end
  end

  // Drive table writes: zero fill after reset, training otherwise
  always_comb begin
    btb_we    = 1'b0;
    btb_waddr = cur_slot;
    btb_wdata = {1'b1, cur_tag, cur.next_pc};
    pht_we    = 1'b0;
    pht_waddr = cur_pidx;
    pht_wdata = ctr_next;
    unique case (state)
      ST_CLEAR: begin
        btb_we    = (clr_cnt < CLR_W'(BTB_ENTRIES));
        btb_waddr = clr_cnt[BTB_AW-1:0];
        btb_wdata = '0;
        pht_we    = (clr_cnt < CLR_W'(PHT_ENTRIES));
        pht_waddr = clr_cnt[PHT_AW-1:0];
        pht_wdata = '0;
      end
      ST_EXEC: begin
        btb_we = fix_target;
        pht_we = cur.branch;
      end
      default: begin
        btb_we = 1'b0;
        pht_we = 1'b0;
      end
    endcase
  end

  bgp_ram #(
    .WIDTH (BTB_W),
    .DEPTH (BTB_ENTRIES)
  ) u_btb (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .raddr (head_slot),
    .rdata (btb_rdata)
  );

  bgp_ram #(
    .WIDTH (2),
    .DEPTH (PHT_ENTRIES)
  ) u_pht (
    .clk   (clk),
    .we    (pht_we),
    .waddr (pht_waddr),
    .wdata (pht_wdata),
    .raddr (head_pidx),
    .rdata (pht_rdata)
  );

  // Sequence clear, read and execute; hold results and running counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      history       <= '0;
      done          <= 1'b0;
      branch_total  <= '0;
      correct_total <= '0;
      hit_total     <= '0;
      miss_total    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (clr_cnt == CLR_W'(MAX_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur      <= q_item;
            cur_pidx <= head_pidx;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done               <= 1'b1;
          predicted_next_pc  <= pred_pc;
          tag_hit            <= hit;
          taken_guess        <= ptaken;
          is_branch          <= cur.branch;
          prediction_correct <= correct;
          if (cur.lookup) begin
            if (hit) begin
              hit_total <= hit_total + 32'd1;
            end else begin
              miss_total <= miss_total + 32'd1;
            end
          end
          if (cur.branch) begin
            branch_total <= branch_total + 32'd1;
            history      <= HISTORY_BITS'({history, cur.taken});
          end
          if (correct) begin
            correct_total <= correct_total + 32'd1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/btb_gshare_branch_predictor.sv
// Channel  Handshake     Payload
// input    start, busy   kind, pc, next_pc
// result   done          predicted_next_pc, tag_hit, taken_guess, is_branch,
//                        prediction_correct, branch_total, correct_total,
//                        hit_total, miss_total
//
// An item is taken when start is high and busy is low; with the back end idle
// its result is registered after the queue, the table read and the exec state and
// shows with done for one cycle; it cannot be held off. The back end reads both
// tables in the idle state and writes them in the exec state, so it takes a new item
// only after the last one is done; a two-entry queue absorbs bursts and busy rises
// while it is full. After reset busy stays high while both tables are zero filled.
module btb_gshare_branch_predictor #(
  parameter int BTB_ENTRIES  = 1024,
  parameter int PHT_ENTRIES  = 256,
  parameter int HISTORY_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        kind,
  input  logic [31:0] pc,
  input  logic [31:0] next_pc,
  output logic        busy,
  output logic        done,
  output logic [31:0] predicted_next_pc,
  output logic        tag_hit,
  output logic        taken_guess,
  output logic        is_branch,
  output logic        prediction_correct,
  output logic [31:0] branch_total,
  output logic [31:0] correct_total,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total
);

  logic           push;
  logic           full;
  logic           clearing;
  logic           q_valid;
  logic           pop;
  bgp_pkg::item_t push_item;
  bgp_pkg::item_t q_item;

  bgp_front u_front (
    .start    (start),
    .kind     (kind),
    .pc       (pc),
    .next_pc  (next_pc),
    .full     (full),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .item     (push_item)
  );

  bgp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .valid     (q_valid),
    .head      (q_item)
  );

  bgp_back #(
    .BTB_ENTRIES  (BTB_ENTRIES),
    .PHT_ENTRIES  (PHT_ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .pop                (pop),
    .clearing           (clearing),
    .done               (done),
    .predicted_next_pc  (predicted_next_pc),
    .tag_hit            (tag_hit),
    .taken_guess        (taken_guess),
    .is_branch          (is_branch),
    .prediction_correct (prediction_correct),
    .branch_total       (branch_total),
    .correct_total      (correct_total),
    .hit_total          (hit_total),
    .miss_total         (miss_total)
  );

endmodule

### sim/btb_gshare_branch_predictor_tb.sv
module btb_gshare_branch_predictor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BTB_SLOTS  = 1024;
  localparam int PHT_SLOTS  = 256;
  localparam int GHIST_BITS = 12;
  localparam int SLOT_BITS  = $clog2(BTB_SLOTS);
  localparam int PAT_BITS   = $clog2(PHT_SLOTS);
  localparam int TAG_BITS   = 32 - SLOT_BITS;

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_AT     = 600;
  localparam int POOL_SIZE    = 24;
  localparam int ALIAS_FROM   = 20;

  // One result item as the block reports it
  typedef struct packed {
    logic [31:0] predicted_next_pc;
    logic        tag_hit;
    logic        taken_guess;
    logic        is_branch;
    logic        prediction_correct;
    logic [31:0] branch_total;
    logic [31:0] correct_total;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_result_t;

  // Mirror of the target buffer, pattern table and totals
  class predictor_mirror;
    bit                    slot_valid [BTB_SLOTS];
    logic [TAG_BITS-1:0]   slot_tag   [BTB_SLOTS];
    logic [31:0]           slot_addr  [BTB_SLOTS];
    logic [1:0]            pattern    [PHT_SLOTS];
    logic [GHIST_BITS-1:0] history;
    logic [31:0]           branches, corrects, hits, misses;
    lookup_result_t        pending_outcomes [$];
    int                    fault_count;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_tag[i]   = '0;
        slot_addr[i]  = '0;
      end
      foreach (pattern[i]) pattern[i] = bgp_pkg::CTR_MIN;
      history     = '0;
      branches    = '0;
      corrects    = '0;
      hits        = '0;
      misses      = '0;
      fault_count = 0;
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    // Work out the result of an accepted item and train the mirror
    function void record_item(logic k, logic [31:0] p, logic [31:0] n);
      lookup_result_t         r;
      logic [31:0]            seq;
      logic [31:0]            tgt;
      logic [SLOT_BITS-1:0]   slot;
      logic [PAT_BITS-1:0]    pidx;
      logic                   taken;
      r    = '0;
      seq  = p + bgp_pkg::SEQ_STEP;
      tgt  = '0;
      slot = p[SLOT_BITS+1:2];
      pidx = p[PAT_BITS+1:2] ^ history[PAT_BITS-1:0];
      if (k == bgp_pkg::KIND_PREDICT || n != p) begin
        if (slot_valid[slot] && slot_tag[slot] == p[31:SLOT_BITS]) begin
          r.tag_hit = 1'b1;
          tgt = slot_addr[slot];
          hits++;
        end else begin
          misses++;
        end
        r.taken_guess = (tgt != 0) && (pattern[pidx] >= bgp_pkg::CTR_TAKEN);
        r.predicted_next_pc = r.taken_guess ? tgt : seq;
        if (k == bgp_pkg::KIND_RESOLVE) begin
          taken = (n != seq);
          r.is_branch = 1'b1;
          branches++;
          r.prediction_correct = (r.taken_guess == taken);
          if (r.prediction_correct) corrects++;
          // rewrite a missing or wrong target
          if (taken && (tgt == 0 || tgt != n)) begin
            slot_valid[slot] = 1'b1;
            slot_tag[slot]   = p[31:SLOT_BITS];
            slot_addr[slot]  = n;
          end
          if (taken) begin
            if (pattern[pidx] < bgp_pkg::CTR_MAX) pattern[pidx] = pattern[pidx] + 2'd1;
          end else begin
            if (pattern[pidx] > bgp_pkg::CTR_MIN) pattern[pidx] = pattern[pidx] - 2'd1;
          end
          history = {history[GHIST_BITS-2:0], taken};
        end
      end
      r.branch_total  = branches;
      r.correct_total = corrects;
      r.hit_total     = hits;
      r.miss_total    = misses;
      pending_outcomes.push_back(r);
    endfunction

    // Compare a reported result with the oldest pending one
    function void match_result(lookup_result_t act);
      lookup_result_t exp;
      logic [31:0]    exp_v [9];
      logic [31:0]    act_v [9];
      string          label [9];
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual pc %h", $time,
                 act.predicted_next_pc);
        fault_count++;
        return;
      end
      exp = pending_outcomes.pop_front();
      label = '{"predicted_next_pc", "tag_hit", "taken_guess", "is_branch",
                "prediction_correct", "branch_total", "correct_total",
                "hit_total", "miss_total"};
      exp_v = '{exp.predicted_next_pc, 32'(exp.tag_hit), 32'(exp.taken_guess),
                32'(exp.is_branch), 32'(exp.prediction_correct), exp.branch_total,
                exp.correct_total, exp.hit_total, exp.miss_total};
      act_v = '{act.predicted_next_pc, 32'(act.tag_hit), 32'(act.taken_guess),
                32'(act.is_branch), 32'(act.prediction_correct), act.branch_total,
                act.correct_total, act.hit_total, act.miss_total};
      foreach (exp_v[i]) begin
        if (exp_v[i] !== act_v[i]) begin
          $display("%0t mismatch %s: expected %h, actual %h", $time, label[i],
                   exp_v[i], act_v[i]);
          fault_count++;
        end
      end
    endfunction
  endclass

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic        kind    = bgp_pkg::KIND_PREDICT;
  logic [31:0] pc      = '0;
  logic [31:0] next_pc = '0;
  logic        busy;
  logic        done;
  logic [31:0] predicted_next_pc;
  logic        tag_hit;
  logic        taken_guess;
  logic        is_branch;
  logic        prediction_correct;
  logic [31:0] branch_total;
  logic [31:0] correct_total;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  predictor_mirror board;

  logic [31:0] pool_pc   [POOL_SIZE];
  logic [31:0] pool_tgt  [POOL_SIZE];
  int          pool_bias [POOL_SIZE];

  btb_gshare_branch_predictor #(
    .BTB_ENTRIES (BTB_SLOTS),
    .PHT_ENTRIES (PHT_SLOTS),
    .HISTORY_BITS(GHIST_BITS)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .kind              (kind),
    .pc                (pc),
    .next_pc           (next_pc),
    .busy              (busy),
    .done              (done),
    .predicted_next_pc (predicted_next_pc),
    .tag_hit           (tag_hit),
    .taken_guess       (taken_guess),
    .is_branch         (is_branch),
    .prediction_correct(prediction_correct),
    .branch_total      (branch_total),
    .correct_total     (correct_total),
    .hit_total         (hit_total),
    .miss_total        (miss_total)
  );

  always #5 clk = ~clk;

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && done) begin
      board.match_result('{predicted_next_pc, tag_hit, taken_guess, is_branch,
                           prediction_correct, branch_total, correct_total,
                           hit_total, miss_total});
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(input logic k, input logic [31:0] p, input logic [31:0] n);
    start   <= 1'b1;
    kind    <= k;
    pc      <= p;
    next_pc <= n;
    do @(posedge clk); while (busy);
    board.record_item(k, p, n);
  endtask

  // Drop start for a number of cycles
  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
  endtask

  // Fill the pool of branch sites, some sharing a buffer slot
  task automatic build_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i >= ALIAS_FROM) begin
        pool_pc[i] = pool_pc[i - ALIAS_FROM];
        pool_pc[i][31:SLOT_BITS+2] = pool_pc[i][31:SLOT_BITS+2] ^
                                     (TAG_BITS-2)'($urandom_range(1, 255));
      end else begin
        pool_pc[i] = $urandom() & 32'hFFFF_FFFC;
      end
      pool_tgt[i]  = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom();
      pool_bias[i] = $urandom_range(0, 100);
    end
  endtask

  // Short list of corner cases
  task automatic run_directed();
    logic [31:0] bpc, btgt, zpc;
    bpc  = 32'h0000_1000;
    btgt = 32'h0000_2000;
    zpc  = 32'h0000_3000;
    send_item(bgp_pkg::KIND_PREDICT, bpc, 32'hFFFF_FFFF);
    send_item(bgp_pkg::KIND_RESOLVE, bpc, bpc);
    // train one site hard toward taken
    repeat (10) send_item(bgp_pkg::KIND_RESOLVE, bpc, btgt);
    send_item(bgp_pkg::KIND_PREDICT, bpc, 32'h0);
    send_item(bgp_pkg::KIND_RESOLVE, bpc, btgt + 32'd8);
    send_item(bgp_pkg::KIND_RESOLVE, bpc, bpc + bgp_pkg::SEQ_STEP);
    send_item(bgp_pkg::KIND_RESOLVE, bpc, bpc + bgp_pkg::SEQ_STEP);
    // sequential address wraps to zero
    send_item(bgp_pkg::KIND_RESOLVE, 32'hFFFF_FFFC, 32'h0);
    // stored target of zero
    send_item(bgp_pkg::KIND_RESOLVE, zpc, 32'h0);
    send_item(bgp_pkg::KIND_PREDICT, zpc, 32'h0);
    send_item(bgp_pkg::KIND_RESOLVE, zpc, 32'h0);
    send_item(bgp_pkg::KIND_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bgp_pkg::KIND_RESOLVE, 32'hFFFF_FFFF, 32'h0000_0003);
    send_item(bgp_pkg::KIND_RESOLVE, 32'h0, 32'h0);
    // same slot, other tag
    send_item(bgp_pkg::KIND_RESOLVE, bpc | 32'h8000_0000, btgt);
    send_item(bgp_pkg::KIND_PREDICT, bpc, 32'h0);
  endtask

  // Mostly trained branch sites, some noise
  task automatic run_random();
    int          sel, mode;
    logic [31:0] p, n;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == DRAIN_AT) drain_results();
      if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 4) == 0)
        idle_for($urandom_range(1, 15));
      sel  = $urandom_range(0, POOL_SIZE - 1);
      mode = $urandom_range(0, 99);
      p    = pool_pc[sel];
      if (mode < 35) begin
        send_item(bgp_pkg::KIND_PREDICT, p, $urandom());
      end else if (mode < 85) begin
        if ($urandom_range(0, 99) < pool_bias[sel]) begin
          if ($urandom_range(0, 19) == 0) pool_tgt[sel] = $urandom();
          n = ($urandom_range(0, 9) == 0) ? $urandom() : pool_tgt[sel];
        end else begin
          n = p + bgp_pkg::SEQ_STEP;
        end
        send_item(bgp_pkg::KIND_RESOLVE, p, n);
      end else if (mode < 90) begin
        send_item(bgp_pkg::KIND_RESOLVE, p, p);
      end else begin
        p = $urandom();
        n = ($urandom_range(0, 3) == 0) ? p + bgp_pkg::SEQ_STEP : $urandom();
        send_item(1'($urandom_range(0, 1)), p, n);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    build_pool();
    run_directed();
    run_random();
    start <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
